/* hdl/hidden_dac_register_access_core_defines.svh */
// Assertion macros for the hidden DAC register access core.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef HIDDEN_DAC_REGISTER_ACCESS_CORE_DEFINES_SVH
`define HIDDEN_DAC_REGISTER_ACCESS_CORE_DEFINES_SVH

// same-cycle implication
`define HDRA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HDRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/hdra_pkg.sv */
// Shared types, constants and decode functions for the hidden DAC register core.
// No dependencies; used by hdra_regfile, hidden_dac_register_access_core and the testbench.
package hdra_pkg;

  localparam int EXT_REG_COUNT = 256;
  localparam int IDX_W = (EXT_REG_COUNT > 1) ? $clog2(EXT_REG_COUNT) : 1;

  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_READ  = 1'b1;

  localparam logic [15:0] PORT_MASK  = 16'h03C6;
  localparam logic [15:0] PORT_RD_IX = 16'h03C7;
  localparam logic [15:0] PORT_DATA  = 16'h03C9;

  localparam logic [2:0] STEP_CTRL = 3'd4;
  localparam logic [2:0] STEP_IDXL = 3'd5;
  localparam logic [2:0] STEP_IDXH = 3'd6;
  localparam logic [2:0] STEP_EXT  = 3'd7;

  localparam logic [7:0] ID_BYTE0 = 8'h44;
  localparam logic [7:0] ID_BYTE1 = 8'h03;
  localparam logic [7:0] ID_BYTE7 = 8'h88;
  localparam logic [7:0] NO_DATA  = 8'hFF;
  localparam logic [7:0] CTRL_RETIME_MASK = 8'hE8;

  localparam logic [15:0] IDX_ID0   = 16'd0;
  localparam logic [15:0] IDX_ID1   = 16'd1;
  localparam logic [15:0] IDX_ID7   = 16'd7;
  localparam logic [15:0] IDX_DEPTH = 16'd3;

  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_15 = 2'd1;
  localparam logic [1:0] DEPTH_16 = 2'd2;
  localparam logic [1:0] DEPTH_24 = 2'd3;

  typedef struct packed {
    logic        command;
    logic [15:0] port_address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pass_to_vga;
    logic [1:0] depth_code;
    logic       timing_update;
  } rsp_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       wdata;
  } rf_cmd_t;

  function automatic logic [2:0] write_next(input logic [2:0] step);
    logic [2:0] nxt;
    unique case (step)
      STEP_IDXL: nxt = STEP_IDXH;
      STEP_IDXH: nxt = STEP_EXT;
      STEP_EXT:  nxt = STEP_EXT;
      default:   nxt = 3'd0;
    endcase
    return nxt;
  endfunction

  function automatic logic [1:0] depth_decode(input logic [7:0] ctrl,
                                              input logic [7:0] ext3);
    logic [1:0] d;
    if (ctrl[3]) begin
      unique case (ext3)
        8'd1, 8'd2, 8'd8: d = DEPTH_15;
        8'd3, 8'd6:       d = DEPTH_16;
        8'd4, 8'd9:       d = DEPTH_24;
        default:          d = DEPTH_8;
      endcase
    end else begin
      unique case (ctrl[7:5])
        3'd5:    d = DEPTH_15;
        3'd6:    d = DEPTH_16;
        3'd7:    d = DEPTH_24;
        default: d = DEPTH_8;
      endcase
    end
    return d;
  endfunction

endpackage

/* hdl/hdra_regfile.sv */
// Extended register file: single-port memory with registered read, per-entry
// valid bits so reset reads as zero, and a flop copy of the depth register.
module hdra_regfile (
  input  logic               clk,
  input  logic               rst,
  input  hdra_pkg::rf_cmd_t  cmd,
  output logic [7:0]         rdata,
  output logic [7:0]         ext3
);

  logic [7:0] mem [hdra_pkg::EXT_REG_COUNT];
  logic [hdra_pkg::EXT_REG_COUNT-1:0] valid;
  logic [7:0] mem_q;
  logic       valid_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
      ext3    <= 8'h00;
    end else begin
      if (cmd.rd_en) begin
        valid_q <= valid[cmd.addr];
      end
      if (cmd.wr_en) begin
        valid[cmd.addr] <= 1'b1;
        if (cmd.addr == hdra_pkg::IDX_DEPTH[hdra_pkg::IDX_W-1:0]) begin
          ext3 <= cmd.wdata;
        end
      end
    end
  end

  assign rdata = valid_q ? mem_q : 8'h00;

endmodule

/* hdl/hidden_dac_register_access_core.sv */
//  channel | payload        | handshake
//  --------+----------------+---------------------------
//  req     | hdra_pkg::req_t | req_valid / req_stall (in)
//  rsp     | hdra_pkg::rsp_t | rsp_valid / rsp_stall (out)
//
// One request per cycle while no response is held by rsp_stall; its response appears the cycle after acceptance.
// Step, control and index state update at the accept edge, so the next request
// sees them at once; the extended register read is the registered memory port.
// Reset clears step, control, index, rsp_valid and the register file valid bits.
// req_stall is high while a response is held by rsp_stall.
// Depends on hdra_pkg, hdra_regfile and the defines header.
`include "hidden_dac_register_access_core_defines.svh"

module hidden_dac_register_access_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  hdra_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output hdra_pkg::rsp_t rsp
);

  logic [2:0]  access_step, access_step_next;
  logic [7:0]  control_reg, control_reg_next;
  logic [15:0] ext_index, ext_index_next;

  logic [7:0] rd_imm, rd_imm_next;
  logic       use_mem, use_mem_next;
  logic       pass, pass_next;
  logic       tupd, tupd_next;
  logic [1:0] depth, depth_next;

  logic              accept;
  logic              is_read, is_mask, is_clr, in_range;
  logic [7:0]        ext3, ext3_next, rf_rdata;
  hdra_pkg::rf_cmd_t rf_cmd;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign is_read  = (req.command == hdra_pkg::CMD_READ);
  assign is_mask  = (req.port_address == hdra_pkg::PORT_MASK);
  assign is_clr   = (req.port_address >= hdra_pkg::PORT_RD_IX) &&
                    (req.port_address <= hdra_pkg::PORT_DATA);
  assign in_range = (ext_index < 16'(hdra_pkg::EXT_REG_COUNT));

  always_comb begin
    access_step_next = access_step;
    control_reg_next = control_reg;
    ext_index_next   = ext_index;
    rd_imm_next      = hdra_pkg::NO_DATA;
    use_mem_next     = 1'b0;
    pass_next        = 1'b1;
    tupd_next        = 1'b0;
    rf_cmd.wr_en     = 1'b0;
    rf_cmd.rd_en     = 1'b0;
    rf_cmd.addr      = ext_index[hdra_pkg::IDX_W-1:0];
    rf_cmd.wdata     = req.write_data;
    if (is_mask) begin
      if (is_read) begin
        pass_next = 1'b0;
        unique case (access_step)
          hdra_pkg::STEP_CTRL: rd_imm_next = control_reg;
          hdra_pkg::STEP_IDXL: rd_imm_next = ext_index[7:0];
          hdra_pkg::STEP_IDXH: rd_imm_next = ext_index[15:8];
          hdra_pkg::STEP_EXT: begin
            priority if (ext_index == hdra_pkg::IDX_ID0) rd_imm_next = hdra_pkg::ID_BYTE0;
            else if (ext_index == hdra_pkg::IDX_ID1)     rd_imm_next = hdra_pkg::ID_BYTE1;
            else if (ext_index == hdra_pkg::IDX_ID7)     rd_imm_next = hdra_pkg::ID_BYTE7;
            else if (in_range) begin
              use_mem_next = 1'b1;
              rf_cmd.rd_en = accept;
            end else begin
              rd_imm_next = hdra_pkg::NO_DATA;
            end
            ext_index_next = ext_index + 16'd1;
          end
          default: rd_imm_next = hdra_pkg::NO_DATA;
        endcase
        // read walk: 0..3 always advance, later steps need control bit 4
        priority if (access_step < hdra_pkg::STEP_CTRL) access_step_next = access_step + 3'd1;
        else if (!control_reg[4])                  access_step_next = 3'd0;
        else if (access_step == hdra_pkg::STEP_EXT) access_step_next = hdra_pkg::STEP_EXT;
        else                                       access_step_next = access_step + 3'd1;
      end else begin
        unique case (access_step)
          hdra_pkg::STEP_CTRL: begin
            control_reg_next = req.write_data;
            tupd_next = |((control_reg ^ req.write_data) & hdra_pkg::CTRL_RETIME_MASK);
          end
          hdra_pkg::STEP_IDXL: ext_index_next = {ext_index[15:8], req.write_data};
          hdra_pkg::STEP_IDXH: ext_index_next = {req.write_data, ext_index[7:0]};
          hdra_pkg::STEP_EXT: begin
            rf_cmd.wr_en   = accept && in_range;
            tupd_next      = (ext_index == hdra_pkg::IDX_DEPTH) && control_reg[3];
            ext_index_next = ext_index + 16'd1;
          end
          default: ;
        endcase
        pass_next        = (access_step < hdra_pkg::STEP_CTRL);
        access_step_next = hdra_pkg::write_next(access_step);
      end
    end else if (is_clr) begin
      access_step_next = 3'd0;
    end
  end

  // depth reflects the state left by this request
  assign ext3_next  = (rf_cmd.wr_en && (ext_index == hdra_pkg::IDX_DEPTH)) ?
                      req.write_data : ext3;
  assign depth_next = hdra_pkg::depth_decode(control_reg_next, ext3_next);

  hdra_regfile u_regfile (
    .clk   (clk),
    .rst   (rst),
    .cmd   (rf_cmd),
    .rdata (rf_rdata),
    .ext3  (ext3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      access_step <= 3'd0;
      control_reg <= 8'h00;
      ext_index   <= 16'h0000;
      rsp_valid   <= 1'b0;
    end else begin
      if (accept) begin
        access_step <= access_step_next;
        control_reg <= control_reg_next;
        ext_index   <= ext_index_next;
        rsp_valid   <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_imm  <= rd_imm_next;
      use_mem <= use_mem_next;
      pass    <= pass_next;
      tupd    <= tupd_next;
      depth   <= depth_next;
    end
  end

  assign rsp.read_data     = use_mem ? rf_rdata : rd_imm;
  assign rsp.pass_to_vga   = pass;
  assign rsp.depth_code    = depth;
  assign rsp.timing_update = tupd;

  `HDRA_ASSERT_NEXT(a_mask_read_local,
    accept && is_read && is_mask, rsp_valid && !rsp.pass_to_vga,
    "read of the mask port was forwarded")
  `HDRA_ASSERT_NOW(a_retime_on_write,
    rsp_valid && rsp.timing_update, rsp.read_data == hdra_pkg::NO_DATA,
    "timing update flagged on a response carrying read data")
  `HDRA_ASSERT_NEXT(a_ext_index_step,
    accept && is_mask && (access_step == hdra_pkg::STEP_EXT),
    ext_index == $past(ext_index) + 16'd1,
    "extended index did not advance on an extended access")

endmodule

/* dv/hidden_dac_register_access_core_tb.sv */
// Testbench for hidden_dac_register_access_core: randomized host I/O requests checked
// against an in-bench model of the DAC unlock sequence and extended register file.
// Depends on hdra_pkg and the core RTL.
module hidden_dac_register_access_core_tb;
  import hdra_pkg::*;

  localparam logic [2:0] STEP_IDLE = 3'd0;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  hidden_dac_register_access_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // model state
  logic [2:0]  dac_step;
  logic [7:0]  dac_ctrl;
  logic [15:0] dac_index;
  logic [7:0]  dac_ext [0:EXT_REG_COUNT-1];

  req_t pending_requests [$];
  rsp_t expected_responses [$];
  int   send_idle_pct;
  int   rcv_idle_pct;
  int   handled_count;
  int   fail_count;
  logic req_accepted;

  function automatic rsp_t predict_dac_response(input req_t r);
    rsp_t o;
    logic [2:0] s;
    s = dac_step;
    o.read_data     = NO_DATA;
    o.pass_to_vga   = 1'b1;
    o.timing_update = 1'b0;
    if (r.port_address == PORT_MASK) begin
      if (r.command == CMD_READ) begin
        o.pass_to_vga = 1'b0;
        case (s)
          STEP_CTRL: o.read_data = dac_ctrl;
          STEP_IDXL: o.read_data = dac_index[7:0];
          STEP_IDXH: o.read_data = dac_index[15:8];
          STEP_EXT: begin
            if (dac_index == IDX_ID0) o.read_data = ID_BYTE0;
            else if (dac_index == IDX_ID1) o.read_data = ID_BYTE1;
            else if (dac_index == IDX_ID7) o.read_data = ID_BYTE7;
            else if (dac_index < 16'(EXT_REG_COUNT))
              o.read_data = dac_ext[dac_index[IDX_W-1:0]];
            dac_index = dac_index + 16'd1;
          end
          default: ;
        endcase
        if (s < STEP_CTRL) dac_step = s + 3'd1;
        else if (!dac_ctrl[4]) dac_step = STEP_IDLE;
        else if (s != STEP_EXT) dac_step = s + 3'd1;
      end else begin
        case (s)
          STEP_CTRL: begin
            if (((dac_ctrl ^ r.write_data) & CTRL_RETIME_MASK) != 8'h00)
              o.timing_update = 1'b1;
            dac_ctrl = r.write_data;
          end
          STEP_IDXL: dac_index[7:0] = r.write_data;
          STEP_IDXH: dac_index[15:8] = r.write_data;
          STEP_EXT: begin
            if (dac_index < 16'(EXT_REG_COUNT))
              dac_ext[dac_index[IDX_W-1:0]] = r.write_data;
            // a depth register write retimes even when the value is unchanged
            if (dac_index == IDX_DEPTH && dac_ctrl[3]) o.timing_update = 1'b1;
            dac_index = dac_index + 16'd1;
          end
          default: ;
        endcase
        o.pass_to_vga = (s < STEP_CTRL);
        case (s)
          STEP_IDXL:          dac_step = STEP_IDXH;
          STEP_IDXH, STEP_EXT: dac_step = STEP_EXT;
          default:            dac_step = STEP_IDLE;
        endcase
      end
    end else if (r.port_address >= PORT_RD_IX && r.port_address <= PORT_DATA) begin
      dac_step = STEP_IDLE;
    end

    if (dac_ctrl[3]) begin
      case (dac_ext[IDX_DEPTH[IDX_W-1:0]])
        8'd1, 8'd2, 8'd8: o.depth_code = DEPTH_15;
        8'd3, 8'd6:       o.depth_code = DEPTH_16;
        8'd4, 8'd9:       o.depth_code = DEPTH_24;
        default:          o.depth_code = DEPTH_8;
      endcase
    end else begin
      case (dac_ctrl[7:5])
        3'd5:    o.depth_code = DEPTH_15;
        3'd6:    o.depth_code = DEPTH_16;
        3'd7:    o.depth_code = DEPTH_24;
        default: o.depth_code = DEPTH_8;
      endcase
    end
    return o;
  endfunction

  task automatic push_req(input logic cmd, input logic [15:0] port, input logic [7:0] data);
    req_t r;
    r.command      = cmd;
    r.port_address = port;
    r.write_data   = data;
    pending_requests.push_back(r);
    if (port >= PORT_MASK && port <= PORT_DATA) handled_count++;
  endtask

  // four reads of the mask port reach the control step
  task automatic queue_unlock();
    repeat (4) push_req(CMD_READ, PORT_MASK, 8'($urandom));
  endtask

  task automatic queue_random_phase(input int target);
    int start;
    int kind;
    logic [7:0] v;
    logic [15:0] ix;
    start = handled_count;
    while (handled_count - start < target) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        // full session: unlock, index, a burst of extended accesses
        queue_unlock();
        push_req(CMD_READ, PORT_MASK, 8'($urandom));
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: ix = 16'($urandom_range(0, 15));
          6, 7:             ix = 16'($urandom_range(0, 255));
          8:                ix = 16'($urandom_range(256, 65535));
          default:          ix = 16'hFFFF - 16'($urandom_range(0, 3));
        endcase
        if ($urandom_range(4) != 0) push_req(CMD_WRITE, PORT_MASK, ix[7:0]);
        else push_req(CMD_READ, PORT_MASK, 8'($urandom));
        if ($urandom_range(4) != 0) push_req(CMD_WRITE, PORT_MASK, ix[15:8]);
        else push_req(CMD_READ, PORT_MASK, 8'($urandom));
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(1)) push_req(CMD_READ, PORT_MASK, 8'($urandom));
          else push_req(CMD_WRITE, PORT_MASK,
                        $urandom_range(1) ? 8'($urandom_range(0, 10)) : 8'($urandom));
        end
        if ($urandom_range(3) != 0)
          push_req(1'($urandom_range(1)), 16'($urandom_range(PORT_RD_IX, PORT_DATA)),
                   8'($urandom));
      end else if (kind < 65) begin
        queue_unlock();
        v = 8'($urandom);
        if ($urandom_range(99) < 85) v[4] = 1'b1;
        push_req(CMD_WRITE, PORT_MASK, v);
      end else if (kind < 80) begin
        // partial unlock that gets broken off
        repeat ($urandom_range(1, 3)) push_req(CMD_READ, PORT_MASK, 8'($urandom));
        if ($urandom_range(1)) push_req(CMD_WRITE, PORT_MASK, 8'($urandom));
        else push_req(1'($urandom_range(1)), 16'($urandom_range(PORT_RD_IX, PORT_DATA)),
                      8'($urandom));
      end else begin
        if ($urandom_range(3) == 0) ix = 16'h03C4 + 16'($urandom_range(0, 7));
        else ix = 16'($urandom);
        push_req(1'($urandom_range(1)), ix, 8'($urandom));
      end
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_stall <= 1'b0;
    end else begin
      if (!req_valid || req_accepted) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req       <= pending_requests.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // response monitor and checker
  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst) begin
      req_accepted <= 1'b0;
    end else begin
      req_accepted <= req_valid && !req_stall;
      if (req_valid && !req_stall) expected_responses.push_back(predict_dac_response(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_responses.size() == 0) begin
          fail_count++;
          $display("%0t unexpected response: expected none, got %h", $time, rsp);
        end else begin
          want = expected_responses.pop_front();
          if (rsp.read_data !== want.read_data) begin
            fail_count++;
            $display("%0t read_data: expected %02h, got %02h",
                     $time, want.read_data, rsp.read_data);
          end
          if (rsp.pass_to_vga !== want.pass_to_vga) begin
            fail_count++;
            $display("%0t pass_to_vga: expected %0b, got %0b",
                     $time, want.pass_to_vga, rsp.pass_to_vga);
          end
          if (rsp.depth_code !== want.depth_code) begin
            fail_count++;
            $display("%0t depth_code: expected %0d, got %0d",
                     $time, want.depth_code, rsp.depth_code);
          end
          if (rsp.timing_update !== want.timing_update) begin
            fail_count++;
            $display("%0t timing_update: expected %0b, got %0b",
                     $time, want.timing_update, rsp.timing_update);
          end
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    req_valid     = 1'b0;
    rsp_stall     = 1'b0;
    req           = '0;
    req_accepted  = 1'b0;
    fail_count    = 0;
    handled_count = 0;
    dac_step      = STEP_IDLE;
    dac_ctrl      = 8'h00;
    dac_index     = 16'h0000;
    foreach (dac_ext[i]) dac_ext[i] = 8'h00;
    send_idle_pct = 38;
    rcv_idle_pct  = 59;

    // directed opening
    push_req(CMD_WRITE, PORT_MASK, 8'hFF);        // pixel mask, forwarded
    queue_unlock();
    push_req(CMD_WRITE, PORT_MASK, 8'hF8);        // control: unlock ext, depth via ext reg 3
    queue_unlock();
    push_req(CMD_READ, PORT_MASK, 8'h00);         // control readback
    push_req(CMD_WRITE, PORT_MASK, 8'hFF);        // index low
    push_req(CMD_WRITE, PORT_MASK, 8'hFF);        // index high
    push_req(CMD_READ, PORT_MASK, 8'h00);         // out of range, index wraps
    push_req(CMD_READ, PORT_MASK, 8'h00);         // ID byte 0
    push_req(CMD_READ, PORT_MASK, 8'h00);         // ID byte 1
    push_req(CMD_WRITE, PORT_MASK, 8'hAA);
    push_req(CMD_WRITE, PORT_MASK, 8'h09);        // depth register -> 24 bpp
    push_req(CMD_READ, PORT_MASK, 8'h00);
    push_req(CMD_WRITE, 16'h03C8, 8'h00);         // clears the step
    push_req(CMD_READ, 16'h0000, 8'h00);
    push_req(CMD_WRITE, 16'hFFFF, 8'hFF);
    push_req(CMD_READ, PORT_DATA, 8'h00);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_random_phase(650);
    while (pending_requests.size() != 0) @(posedge clk);
    send_idle_pct = 59;
    rcv_idle_pct  = 38;
    queue_random_phase(650);
    while (pending_requests.size() != 0) @(posedge clk);
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    queue_random_phase(650);

    while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/hdra_pkg.sv
hdl/hdra_regfile.sv
hdl/hidden_dac_register_access_core.sv
dv/hidden_dac_register_access_core_tb.sv
